// File: hw/rtl/plce_pkg.sv
package plce_pkg;

  localparam int NUM_LISTS_DEF = 16;
  localparam int NUM_NODES_DEF = 256;
  localparam int ITEM_BITS_DEF = 32;

  typedef enum logic [3:0] {
    OP_CREATE     = 4'd0,
    OP_COUNT      = 4'd1,
    OP_FIRST      = 4'd2,
    OP_LAST       = 4'd3,
    OP_NEXT       = 4'd4,
    OP_PREV       = 4'd5,
    OP_CURR       = 4'd6,
    OP_INS_AFTER  = 4'd7,
    OP_INS_BEFORE = 4'd8,
    OP_APPEND     = 4'd9,
    OP_PREPEND    = 4'd10,
    OP_REMOVE     = 4'd11,
    OP_TRIM       = 4'd12,
    OP_CONCAT     = 4'd13,
    OP_FREE       = 4'd14
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EXHAUST = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef struct packed {
    logic [3:0]  operation;
    logic [3:0]  list_id;
    logic [3:0]  second_list_id;
    logic [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] item_out;
    logic        item_valid;
    logic [3:0]  new_list_id;
    logic [8:0]  length_out;
  } out_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DISP, S_NPB, S_GET, S_INSB, S_INSC, S_INSD,
    S_UNB, S_UNC, S_CCB, S_FRB, S_FRE, S_FIN
  } state_t;

  typedef enum logic [4:0] {
    U_NOP, U_CLR, U_LOAD, U_BAD, U_CREATE, U_FL, U_NP, U_NPB, U_CUR, U_GET,
    U_INSA, U_INSB, U_INSC, U_INSD, U_UNA, U_UNB, U_UNC, U_CCA, U_CCB,
    U_FRA, U_FRB, U_FRE, U_FIN
  } uop_t;

  typedef struct packed {
    logic [3:0] op;
    logic       hok;
    logic       h2ok;
    logic       clr_last;
    logic       go;
    logic       alt;
    logic       out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/plce_ctrl.sv
module plce_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  plce_pkg::dp_status_t   st,
  output plce_pkg::uop_t         uop
);
  import plce_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    uop       = U_NOP;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_CLR: begin
        uop = U_CLR;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          uop       = U_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        if (st.op == OP_CREATE) begin
          uop = U_CREATE;
        end else if (st.op > OP_FREE || !st.hok) begin
          uop = U_BAD;
        end else begin
          case (st.op)
            OP_COUNT: uop = U_NOP;
            OP_FIRST, OP_LAST: begin
              uop = U_FL;
              if (st.go) state_nxt = S_GET;
            end
            OP_NEXT, OP_PREV: begin
              uop = U_NP;
              if (st.go) state_nxt = S_GET;
              else if (st.alt) state_nxt = S_NPB;
            end
            OP_CURR: begin
              uop = U_CUR;
              if (st.go) state_nxt = S_GET;
            end
            OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
              uop = U_INSA;
              if (st.go) state_nxt = S_INSB;
            end
            OP_REMOVE, OP_TRIM: begin
              uop = U_UNA;
              if (st.go) state_nxt = S_UNB;
            end
            OP_CONCAT: begin
              if (st.h2ok) begin
                uop       = U_CCA;
                state_nxt = S_CCB;
              end else begin
                uop = U_BAD;
              end
            end
            OP_FREE: begin
              uop       = U_FRA;
              state_nxt = st.go ? S_FRB : S_FRE;
            end
            default: uop = U_BAD;
          endcase
        end
      end
      S_NPB: begin
        uop       = U_NPB;
        state_nxt = st.go ? S_GET : S_FIN;
      end
      S_GET: begin
        uop       = U_GET;
        state_nxt = S_FIN;
      end
      S_INSB: begin
        uop       = U_INSB;
        state_nxt = S_INSC;
      end
      S_INSC: begin
        uop       = U_INSC;
        state_nxt = S_INSD;
      end
      S_INSD: begin
        uop       = U_INSD;
        state_nxt = S_FIN;
      end
      S_UNB: begin
        uop       = U_UNB;
        state_nxt = S_UNC;
      end
      S_UNC: begin
        uop       = U_UNC;
        state_nxt = S_FIN;
      end
      S_CCB: begin
        uop       = U_CCB;
        state_nxt = S_FIN;
      end
      S_FRB: begin
        uop       = U_FRB;
        state_nxt = st.go ? S_FRB : S_FRE;
      end
      S_FRE: begin
        uop       = U_FRE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        uop = U_FIN;
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/plce_dp.sv
module plce_dp #(
  parameter int NUM_LISTS = plce_pkg::NUM_LISTS_DEF,
  parameter int NUM_NODES = plce_pkg::NUM_NODES_DEF,
  parameter int ITEM_BITS = plce_pkg::ITEM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plce_pkg::in_t        in_data,
  input  plce_pkg::uop_t       uop,
  output plce_pkg::dp_status_t st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output plce_pkg::out_t       out_data
);
  import plce_pkg::*;

  localparam int NW   = $clog2(NUM_NODES);
  localparam int NP   = NW + 1;
  localparam int LW   = $clog2(NUM_LISTS);
  localparam int LP   = LW + 1;
  localparam logic [NP-1:0] NNONE = NP'(NUM_NODES);
  localparam logic [LP-1:0] LNONE = LP'(NUM_LISTS);

  function automatic logic isn(input logic [NP-1:0] v);
    return v < NNONE;
  endfunction

  function automatic logic [NW-1:0] na(input logic [NP-1:0] v);
    return v[NW-1:0];
  endfunction

  // list records
  logic [NP-1:0] head_r [NUM_LISTS];
  logic [NP-1:0] tail_r [NUM_LISTS];
  logic [NP-1:0] cur_r  [NUM_LISTS];
  logic          bey_r  [NUM_LISTS];
  logic [NP-1:0] len_r  [NUM_LISTS];
  logic [LP-1:0] hchain_r [NUM_LISTS];
  logic [LP-1:0] htop_r, htop_nxt;
  logic [NP-1:0] ntop_r, ntop_nxt;

  // node memories
  logic [NP-1:0]        fwd_m   [NUM_NODES];
  logic [NP-1:0]        bwd_m   [NUM_NODES];
  logic [NP-1:0]        chain_m [NUM_NODES];
  logic [ITEM_BITS-1:0] item_m  [NUM_NODES];
  logic [NP-1:0]        fwd_q, bwd_q, chain_q;
  logic [ITEM_BITS-1:0] item_q;
  logic [NW-1:0]        raddr;

  logic          fwd_we, bwd_we, ch_we, it_we;
  logic [NW-1:0] fwd_wa, bwd_wa, ch_wa, it_wa;
  logic [NP-1:0] fwd_wd, bwd_wd, ch_wd;
  logic [ITEM_BITS-1:0] it_wd;

  // working copy of the addressed list and of the concat source
  in_t           req_r, req_nxt;
  logic [NP-1:0] lh_r, lh_nxt, lt_r, lt_nxt, lc_r, lc_nxt, ll_r, ll_nxt;
  logic          lb_r, lb_nxt;
  logic [NP-1:0] mh_r, mh_nxt, mt_r, mt_nxt, ml_r, ml_nxt;
  logic [NP-1:0] n_r, n_nxt, pv_r, pv_nxt, nx_r, nx_nxt, k_r, k_nxt;
  logic [NW-1:0] clr_r, clr_nxt;
  logic [1:0]    rs_r, rs_nxt;
  logic [ITEM_BITS-1:0] ri_r, ri_nxt;
  logic          rv_r, rv_nxt, nolen_r, nolen_nxt;
  logic [3:0]    rn_r, rn_nxt;
  out_t          out_r, out_nxt;
  logic          out_valid_r, ov_nxt;

  logic          rec_we;
  logic [LW-1:0] rec_wa;
  logic [NP-1:0] rw_head, rw_tail, rw_cur, rw_len;
  logic          rw_bey;
  logic          hc_we;
  logic [LW-1:0] hc_wa;
  logic [LP-1:0] hc_wd;

  logic [7:0]    in_h8, h8, h28;
  logic [LW-1:0] in_hidx, hidx, h2idx;
  logic [63:0]   val64, ri64;
  logic [ITEM_BITS-1:0] val_i;
  logic [31:0]   len32;
  logic [8:0]    htop9;
  logic          fwd_dir, out_free, go, alt;

  assign in_h8   = {4'b0, in_data.list_id};
  assign h8      = {4'b0, req_r.list_id};
  assign h28     = {4'b0, req_r.second_list_id};
  assign in_hidx = in_h8[LW-1:0];
  assign hidx    = h8[LW-1:0];
  assign h2idx   = h28[LW-1:0];
  assign val64   = {32'b0, req_r.item_value};
  assign val_i   = val64[ITEM_BITS-1:0];
  assign ri64    = 64'(ri_r);
  assign len32   = 32'(ll_r);
  assign htop9   = 9'(htop_r);
  assign fwd_dir = (req_r.operation == OP_NEXT);
  assign out_free = !out_valid_r || out_ready;

  assign st.op       = req_r.operation;
  assign st.hok      = 9'(req_r.list_id) < 9'(NUM_LISTS);
  assign st.h2ok     = (9'(req_r.second_list_id) < 9'(NUM_LISTS)) &&
                       (req_r.second_list_id != req_r.list_id);
  assign st.clr_last = (clr_r == NW'(NUM_NODES - 1));
  assign st.go       = go;
  assign st.alt      = alt;
  assign st.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    req_nxt = req_r;
    lh_nxt = lh_r; lt_nxt = lt_r; lc_nxt = lc_r; lb_nxt = lb_r; ll_nxt = ll_r;
    mh_nxt = mh_r; mt_nxt = mt_r; ml_nxt = ml_r;
    n_nxt = n_r; pv_nxt = pv_r; nx_nxt = nx_r; k_nxt = k_r; clr_nxt = clr_r;
    rs_nxt = rs_r; ri_nxt = ri_r; rv_nxt = rv_r; rn_nxt = rn_r; nolen_nxt = nolen_r;
    htop_nxt = htop_r; ntop_nxt = ntop_r;
    out_nxt = out_r;
    ov_nxt  = out_valid_r && !out_ready;
    go = 1'b0; alt = 1'b0;
    raddr  = na(lc_r);
    fwd_we = 1'b0; fwd_wa = na(n_r); fwd_wd = NNONE;
    bwd_we = 1'b0; bwd_wa = na(n_r); bwd_wd = NNONE;
    ch_we  = 1'b0; ch_wa  = na(n_r); ch_wd  = ntop_r;
    it_we  = 1'b0; it_wa  = na(ntop_r); it_wd = val_i;
    rec_we = 1'b0; rec_wa = hidx;
    rw_head = lh_r; rw_tail = lt_r; rw_cur = lc_r; rw_bey = lb_r; rw_len = ll_r;
    hc_we = 1'b0; hc_wa = hidx; hc_wd = htop_r;
    case (uop)
      U_CLR: begin
        fwd_we = 1'b1; fwd_wa = clr_r;
        bwd_we = 1'b1; bwd_wa = clr_r;
        ch_we  = 1'b1; ch_wa  = clr_r; ch_wd = NP'(clr_r) + NP'(1);
        clr_nxt = clr_r + NW'(1);
      end
      U_LOAD: begin
        req_nxt = in_data;
        lh_nxt = head_r[in_hidx]; lt_nxt = tail_r[in_hidx];
        lc_nxt = cur_r[in_hidx];  lb_nxt = bey_r[in_hidx];
        ll_nxt = len_r[in_hidx];
        rs_nxt = ST_OK; ri_nxt = '0; rv_nxt = 1'b0; rn_nxt = '0; nolen_nxt = 1'b0;
      end
      U_BAD: begin
        // a refused concat still reports the length of its list
        rs_nxt = ST_BAD; nolen_nxt = (req_r.operation != OP_CONCAT);
      end
      U_CREATE: begin
        nolen_nxt = 1'b1;
        if (htop_r < LNONE) begin
          htop_nxt = hchain_r[htop_r[LW-1:0]];
          rec_we = 1'b1; rec_wa = htop_r[LW-1:0];
          rw_head = NNONE; rw_tail = NNONE; rw_cur = NNONE; rw_bey = 1'b0; rw_len = '0;
          rn_nxt = htop9[3:0];
        end else begin
          rs_nxt = ST_EXHAUST;
        end
      end
      U_FL: begin
        n_nxt = (req_r.operation == OP_FIRST) ? lh_r : lt_r;
        if (ll_r == '0 || !isn(n_nxt)) begin
          lc_nxt = NNONE; rs_nxt = ST_BAD;
        end else begin
          lc_nxt = n_nxt; raddr = na(n_nxt); go = 1'b1;
        end
      end
      U_NP: begin
        if (!isn(lc_r)) begin
          if (ll_r == '0 || !isn(lh_r)) begin
            lb_nxt = fwd_dir; rs_nxt = ST_BAD;
          end else if (fwd_dir && !lb_r) begin
            lc_nxt = lh_r; raddr = na(lh_r); go = 1'b1;
          end else if (!fwd_dir && lb_r && isn(lt_r)) begin
            lc_nxt = lt_r; raddr = na(lt_r); go = 1'b1;
          end else begin
            rs_nxt = ST_BAD;
          end
        end else begin
          raddr = na(lc_r); alt = 1'b1;
        end
      end
      U_NPB: begin
        n_nxt = fwd_dir ? fwd_q : bwd_q;
        if (!isn(n_nxt)) begin
          lc_nxt = NNONE; lb_nxt = fwd_dir; rs_nxt = ST_BAD;
        end else begin
          lc_nxt = n_nxt; raddr = na(n_nxt); go = 1'b1;
        end
      end
      U_CUR: begin
        if (isn(lc_r)) go = 1'b1;
        else rs_nxt = ST_BAD;
      end
      U_GET: begin
        ri_nxt = item_q; rv_nxt = 1'b1;
      end
      U_INSA: begin
        if (!isn(ntop_r)) begin
          rs_nxt = ST_EXHAUST;
        end else begin
          n_nxt = ntop_r; raddr = na(ntop_r); it_we = 1'b1; go = 1'b1;
        end
      end
      U_INSB: begin
        ntop_nxt = chain_q;
      end
      U_INSC: begin
        if (!isn(lh_r) || !isn(lt_r)) begin
          pv_nxt = NNONE; nx_nxt = NNONE;
        end else if ((req_r.operation == OP_INS_AFTER ||
                      req_r.operation == OP_INS_BEFORE) && isn(lc_r)) begin
          if (req_r.operation == OP_INS_AFTER) begin
            pv_nxt = lc_r; nx_nxt = fwd_q;
          end else begin
            pv_nxt = bwd_q; nx_nxt = lc_r;
          end
        end else if (req_r.operation == OP_PREPEND ||
                     (req_r.operation != OP_APPEND && !lb_r)) begin
          pv_nxt = NNONE; nx_nxt = lh_r;
        end else begin
          pv_nxt = lt_r; nx_nxt = NNONE;
        end
        if (!isn(pv_nxt)) pv_nxt = NNONE;
        if (!isn(nx_nxt)) nx_nxt = NNONE;
        fwd_we = 1'b1; fwd_wd = nx_nxt;
        bwd_we = 1'b1; bwd_wd = pv_nxt;
      end
      U_INSD: begin
        if (isn(pv_r)) begin
          fwd_we = 1'b1; fwd_wa = na(pv_r); fwd_wd = n_r;
        end else begin
          lh_nxt = n_r;
        end
        if (isn(nx_r)) begin
          bwd_we = 1'b1; bwd_wa = na(nx_r); bwd_wd = n_r;
        end else begin
          lt_nxt = n_r;
        end
        lc_nxt = n_r;
        ll_nxt = ll_r + NP'(1);
      end
      U_UNA: begin
        if (req_r.operation == OP_REMOVE) begin
          n_nxt = lc_r; go = isn(lc_r);
        end else begin
          n_nxt = lt_r; go = (ll_r != '0) && isn(lt_r);
        end
        if (go) raddr = na(n_nxt);
        else rs_nxt = ST_BAD;
      end
      U_UNB: begin
        ri_nxt = item_q; rv_nxt = 1'b1;
        if (isn(bwd_q)) begin
          fwd_we = 1'b1; fwd_wa = na(bwd_q); fwd_wd = fwd_q;
        end else begin
          lh_nxt = isn(fwd_q) ? fwd_q : NNONE;
        end
        if (isn(fwd_q)) begin
          bwd_we = 1'b1; bwd_wa = na(fwd_q); bwd_wd = bwd_q;
        end else begin
          lt_nxt = isn(bwd_q) ? bwd_q : NNONE;
        end
        lc_nxt = isn(fwd_q) ? fwd_q : (isn(bwd_q) ? bwd_q : NNONE);
        if (ll_r != '0) ll_nxt = ll_r - NP'(1);
      end
      U_UNC: begin
        fwd_we = 1'b1; bwd_we = 1'b1; ch_we = 1'b1;
        ntop_nxt = n_r;
      end
      U_CCA: begin
        mh_nxt = head_r[h2idx]; mt_nxt = tail_r[h2idx]; ml_nxt = len_r[h2idx];
      end
      U_CCB: begin
        if (isn(mh_r) && isn(mt_r)) begin
          if (isn(lt_r) && isn(lh_r)) begin
            fwd_we = 1'b1; fwd_wa = na(lt_r); fwd_wd = mh_r;
            bwd_we = 1'b1; bwd_wa = na(mh_r); bwd_wd = lt_r;
          end else begin
            lh_nxt = mh_r;
          end
          lt_nxt = mt_r;
        end
        ll_nxt = ll_r + ml_r;
        rec_we = 1'b1; rec_wa = h2idx;
        rw_head = NNONE; rw_tail = NNONE; rw_cur = NNONE; rw_bey = 1'b0; rw_len = '0;
        hc_we = 1'b1; hc_wa = h2idx;
        htop_nxt = LP'(h2idx);
      end
      U_FRA: begin
        k_nxt = '0;
        n_nxt = lh_r;
        raddr = na(lh_r);
        go = isn(lh_r);
      end
      U_FRB: begin
        fwd_we = 1'b1; bwd_we = 1'b1; ch_we = 1'b1;
        ntop_nxt = n_r;
        n_nxt = fwd_q;
        raddr = na(fwd_q);
        k_nxt = k_r + NP'(1);
        go = isn(fwd_q) && (k_r < NP'(NUM_NODES - 1));
      end
      U_FRE: begin
        lh_nxt = NNONE; lt_nxt = NNONE; lc_nxt = NNONE; lb_nxt = 1'b0; ll_nxt = '0;
        hc_we = 1'b1;
        htop_nxt = LP'(hidx);
      end
      U_FIN: begin
        if (out_free) begin
          out_nxt.status      = rs_r;
          out_nxt.item_out    = ri64[31:0];
          out_nxt.item_valid  = rv_r;
          out_nxt.new_list_id = rn_r;
          out_nxt.length_out  = nolen_r ? 9'd0 : len32[8:0];
          ov_nxt = 1'b1;
          rec_we = !nolen_r;
        end
      end
      default: ;
    endcase
  end

  // node memories: registered read, new data on a same-address write
  always_ff @(posedge clk) begin
    if (fwd_we) fwd_m[fwd_wa] <= fwd_wd;
    if (bwd_we) bwd_m[bwd_wa] <= bwd_wd;
    if (ch_we)  chain_m[ch_wa] <= ch_wd;
    if (it_we)  item_m[it_wa] <= it_wd;
    fwd_q   <= (fwd_we && fwd_wa == raddr) ? fwd_wd : fwd_m[raddr];
    bwd_q   <= (bwd_we && bwd_wa == raddr) ? bwd_wd : bwd_m[raddr];
    chain_q <= (ch_we && ch_wa == raddr) ? ch_wd : chain_m[raddr];
    item_q  <= (it_we && it_wa == raddr) ? it_wd : item_m[raddr];
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    lh_r <= lh_nxt; lt_r <= lt_nxt; lc_r <= lc_nxt; lb_r <= lb_nxt; ll_r <= ll_nxt;
    mh_r <= mh_nxt; mt_r <= mt_nxt; ml_r <= ml_nxt;
    n_r <= n_nxt; pv_r <= pv_nxt; nx_r <= nx_nxt; k_r <= k_nxt;
    rs_r <= rs_nxt; ri_r <= ri_nxt; rv_r <= rv_nxt; rn_r <= rn_nxt;
    nolen_r <= nolen_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_r[i]   <= NNONE;
        tail_r[i]   <= NNONE;
        cur_r[i]    <= NNONE;
        bey_r[i]    <= 1'b0;
        len_r[i]    <= '0;
        hchain_r[i] <= LP'(i + 1);
      end
      htop_r      <= '0;
      ntop_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (rec_we) begin
        head_r[rec_wa] <= rw_head;
        tail_r[rec_wa] <= rw_tail;
        cur_r[rec_wa]  <= rw_cur;
        bey_r[rec_wa]  <= rw_bey;
        len_r[rec_wa]  <= rw_len;
      end
      if (hc_we) hchain_r[hc_wa] <= hc_wd;
      htop_r      <= htop_nxt;
      ntop_r      <= ntop_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= ov_nxt;
    end
  end

  a_item_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.item_valid |-> out_r.status == ST_OK)
    else $error("item returned with an error status");

  a_null_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.item_valid |-> out_r.item_out == '0)
    else $error("null item not zero");

  a_fin_loads : assert property (@(posedge clk) disable iff (!rst_n)
    uop == U_FIN && out_free |=> out_valid_r)
    else $error("finished request not presented");

  a_ntop_range : assert property (@(posedge clk) disable iff (!rst_n)
    ntop_r <= NNONE)
    else $error("free node stack top out of range");

  a_htop_range : assert property (@(posedge clk) disable iff (!rst_n)
    htop_r <= LNONE)
    else $error("free handle stack top out of range");

endmodule

// File: hw/rtl/pooled_list_cursor_engine.sv
// Channel | Signals                         | Moves
// in      | in_valid, in_ready, in_data     | one command request
// out     | out_valid, out_ready, out_data  | one result per request
//
// Create, count and any request refused at its first check go from dispatch
// straight to finish; navigation, current, concat, remove, trim and inserts
// add node read or write steps in between, and free walks the whole list;
// the single node memory read port sets these steps.
// After reset a clearing pass over all NUM_NODES entries initialises the node
// links and free chain; no request is taken meanwhile.
// The result register lets the next request enter while a result waits;
// a request finishing into a full result register holds until it drains.
module pooled_list_cursor_engine #(
  parameter int NUM_LISTS = plce_pkg::NUM_LISTS_DEF,
  parameter int NUM_NODES = plce_pkg::NUM_NODES_DEF,
  parameter int ITEM_BITS = plce_pkg::ITEM_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  plce_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output plce_pkg::out_t out_data
);
  import plce_pkg::*;

  uop_t       uop;
  dp_status_t st;

  // sequence each request through its read/modify/write steps
  plce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .uop      (uop)
  );

  // list records, free stacks, node memories and the result register
  plce_dp #(
    .NUM_LISTS (NUM_LISTS),
    .NUM_NODES (NUM_NODES),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .uop       (uop),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plce_pkg::*;

  localparam int LISTS = 16;
  localparam int NODES = 256;
  localparam int NIL_NODE = NODES;
  localparam int NIL_HANDLE = LISTS;
  localparam int LIMIT_CYCLES = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pooled_list_cursor_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the list and node tables
  int lst_head[LISTS];
  int lst_tail[LISTS];
  int lst_cur[LISTS];
  bit lst_beyond[LISTS];
  int lst_len[LISTS];
  int hnd_chain[LISTS];
  int hnd_top;
  logic [31:0] nd_item[NODES];
  bit nd_written[NODES];
  int nd_fwd[NODES];
  int nd_bwd[NODES];
  int nd_chain[NODES];
  int nd_top;
  bit live[LISTS];

  out_t pending_results[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int cycles = 0;
  int op_seen[16];

  function automatic bit is_nd(int n);
    return n < NIL_NODE;
  endfunction

  function automatic void wipe_list(int h);
    lst_head[h] = NIL_NODE;
    lst_tail[h] = NIL_NODE;
    lst_cur[h] = NIL_NODE;
    lst_beyond[h] = 0;
    lst_len[h] = 0;
  endfunction

  function automatic void give_back_node(int n);
    nd_fwd[n] = NIL_NODE;
    nd_bwd[n] = NIL_NODE;
    nd_chain[n] = nd_top;
    nd_top = n;
  endfunction

  function automatic void give_back_handle(int h);
    wipe_list(h);
    hnd_chain[h] = hnd_top;
    hnd_top = h;
    live[h] = 0;
  endfunction

  function automatic logic [31:0] detach_node(int h, int n);
    logic [31:0] it;
    int nx, pv;
    it = nd_item[n];
    nx = nd_fwd[n];
    pv = nd_bwd[n];
    if (is_nd(pv)) nd_fwd[pv] = nx; else lst_head[h] = nx;
    if (is_nd(nx)) nd_bwd[nx] = pv; else lst_tail[h] = pv;
    lst_cur[h] = is_nd(nx) ? nx : pv;
    give_back_node(n);
    if (lst_len[h] > 0) lst_len[h]--;
    return it;
  endfunction

  // mode: 0 after cursor, 1 before cursor, 2 at end, 3 at start
  function automatic void attach_node(int h, int n, int mode);
    int c, pv, nx;
    c = lst_cur[h];
    if (!is_nd(lst_head[h]) || !is_nd(lst_tail[h])) begin
      pv = NIL_NODE; nx = NIL_NODE;
    end else if (mode <= 1 && is_nd(c)) begin
      if (mode == 0) begin
        pv = c; nx = nd_fwd[c];
      end else begin
        pv = nd_bwd[c]; nx = c;
      end
    end else if (mode == 3 || (mode <= 1 && !lst_beyond[h])) begin
      pv = NIL_NODE; nx = lst_head[h];
    end else begin
      pv = lst_tail[h]; nx = NIL_NODE;
    end
    nd_bwd[n] = pv;
    nd_fwd[n] = nx;
    if (is_nd(pv)) nd_fwd[pv] = n; else lst_head[h] = n;
    if (is_nd(nx)) nd_bwd[nx] = n; else lst_tail[h] = n;
    lst_cur[h] = n;
    lst_len[h]++;
  endfunction

  function automatic void reset_tables();
    for (int i = 0; i < LISTS; i++) begin
      wipe_list(i);
      hnd_chain[i] = i + 1;
      live[i] = 0;
    end
    hnd_top = 0;
    for (int i = 0; i < NODES; i++) begin
      nd_fwd[i] = NIL_NODE;
      nd_bwd[i] = NIL_NODE;
      nd_chain[i] = i + 1;
      nd_written[i] = 0;
      nd_item[i] = '0;
    end
    nd_top = 0;
  endfunction

  // Work out the result of one command and advance the shadow tables
  function automatic out_t list_command_result(in_t req);
    out_t r;
    int h, h2, n, c, nx, k;
    bit hok, fwd;
    r = '0;
    h = req.list_id;
    h2 = req.second_list_id;
    hok = 1;
    case (req.operation)
      OP_CREATE: begin
        if (hnd_top < LISTS) begin
          n = hnd_top;
          hnd_top = hnd_chain[n];
          wipe_list(n);
          live[n] = 1;
          r.new_list_id = n[3:0];
        end else begin
          r.status = ST_EXHAUST;
        end
        hok = 0;
      end
      OP_COUNT: ;
      OP_FIRST, OP_LAST: begin
        n = (req.operation == OP_FIRST) ? lst_head[h] : lst_tail[h];
        if (lst_len[h] == 0 || !is_nd(n)) begin
          lst_cur[h] = NIL_NODE;
          r.status = ST_BAD;
        end else begin
          lst_cur[h] = n;
          r.item_out = nd_item[n];
          r.item_valid = 1;
        end
      end
      OP_NEXT, OP_PREV: begin
        fwd = (req.operation == OP_NEXT);
        c = lst_cur[h];
        if (!is_nd(c)) begin
          if (lst_len[h] == 0 || !is_nd(lst_head[h])) begin
            lst_beyond[h] = fwd;
            r.status = ST_BAD;
          end else if (fwd && !lst_beyond[h]) begin
            lst_cur[h] = lst_head[h];
            r.item_out = nd_item[lst_head[h]];
            r.item_valid = 1;
          end else if (!fwd && lst_beyond[h] && is_nd(lst_tail[h])) begin
            lst_cur[h] = lst_tail[h];
            r.item_out = nd_item[lst_tail[h]];
            r.item_valid = 1;
          end else begin
            r.status = ST_BAD;
          end
        end else begin
          n = fwd ? nd_fwd[c] : nd_bwd[c];
          if (!is_nd(n)) begin
            lst_cur[h] = NIL_NODE;
            lst_beyond[h] = fwd;
            r.status = ST_BAD;
          end else begin
            lst_cur[h] = n;
            r.item_out = nd_item[n];
            r.item_valid = 1;
          end
        end
      end
      OP_CURR: begin
        if (is_nd(lst_cur[h])) begin
          r.item_out = nd_item[lst_cur[h]];
          r.item_valid = 1;
        end else begin
          r.status = ST_BAD;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE, OP_APPEND, OP_PREPEND: begin
        if (!is_nd(nd_top)) begin
          r.status = ST_EXHAUST;
        end else begin
          n = nd_top;
          nd_top = nd_chain[n];
          nd_item[n] = req.item_value;
          nd_written[n] = 1;
          attach_node(h, n, int'(req.operation) - int'(OP_INS_AFTER));
        end
      end
      OP_REMOVE: begin
        if (is_nd(lst_cur[h])) begin
          r.item_out = detach_node(h, lst_cur[h]);
          r.item_valid = 1;
        end else begin
          r.status = ST_BAD;
        end
      end
      OP_TRIM: begin
        if (lst_len[h] != 0 && is_nd(lst_tail[h])) begin
          r.item_out = detach_node(h, lst_tail[h]);
          r.item_valid = 1;
        end else begin
          r.status = ST_BAD;
        end
      end
      OP_CONCAT: begin
        if (h2 == h) begin
          r.status = ST_BAD;
        end else begin
          if (is_nd(lst_head[h2]) && is_nd(lst_tail[h2])) begin
            if (is_nd(lst_tail[h]) && is_nd(lst_head[h])) begin
              nd_fwd[lst_tail[h]] = lst_head[h2];
              nd_bwd[lst_head[h2]] = lst_tail[h];
            end else begin
              lst_head[h] = lst_head[h2];
            end
            lst_tail[h] = lst_tail[h2];
          end
          lst_len[h] += lst_len[h2];
          give_back_handle(h2);
        end
      end
      OP_FREE: begin
        n = lst_head[h];
        for (k = 0; k < NODES && is_nd(n); k++) begin
          nx = nd_fwd[n];
          give_back_node(n);
          n = nx;
        end
        give_back_handle(h);
      end
      default: begin
        r.status = ST_BAD;
        hok = 0;
      end
    endcase
    if (hok) r.length_out = lst_len[h][8:0];
    return r;
  endfunction

  // Send one request: random gap, then hold valid until accepted; returns at
  // the accepting edge with valid still high so a zero gap runs back to back
  task automatic send_request(input in_t req);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(list_command_result(req));
    op_seen[req.operation]++;
    sent++;
  endtask

  task automatic send_op(input logic [3:0] op, input int h, input int h2,
                         input logic [31:0] v);
    in_t req;
    req.operation = op;
    req.list_id = h[3:0];
    req.second_list_id = h2[3:0];
    req.item_value = v;
    send_request(req);
  endtask

  // Result checker: one result per accepted request, compared in order
  initial begin
    out_t want;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        received++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime,
                     want.status, out_data.status);
            errors++;
          end
          if (out_data.item_out !== want.item_out) begin
            $display("%0t: item_out expected %h actual %h", $realtime,
                     want.item_out, out_data.item_out);
            errors++;
          end
          if (out_data.item_valid !== want.item_valid) begin
            $display("%0t: item_valid expected %0d actual %0d", $realtime,
                     want.item_valid, out_data.item_valid);
            errors++;
          end
          if (out_data.new_list_id !== want.new_list_id) begin
            $display("%0t: new_list_id expected %0d actual %0d", $realtime,
                     want.new_list_id, out_data.new_list_id);
            errors++;
          end
          if (out_data.length_out !== want.length_out) begin
            $display("%0t: length_out expected %0d actual %0d", $realtime,
                     want.length_out, out_data.length_out);
            errors++;
          end
        end
      end
    end
  end

  // Receiver back-pressure: drop ready for a random stretch after each result,
  // with whole stretches of no stall at all
  initial begin
    int stall;
    bit calm;
    calm = 0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) calm = ~calm;
      stall = calm ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // Watchdog: worst case is roughly 1400 requests plus gaps and stalls, and
  // LIMIT_CYCLES leaves a wide margin over that
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drop valid, then hold off until every expected result has come
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Pick a handle: mostly a live list, sometimes any handle at all
  function automatic int pick_handle();
    int pool[$];
    for (int i = 0; i < LISTS; i++) if (live[i]) pool.push_back(i);
    if (pool.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 15);
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // Reads through a never-created handle could reach an unwritten node only
  // via stale links; the shadow tables say whether a read is safe
  function automatic bit read_safe(logic [3:0] op, int h);
    int n;
    case (op)
      OP_FIRST: n = (lst_len[h] != 0) ? lst_head[h] : NIL_NODE;
      OP_LAST, OP_TRIM: n = (lst_len[h] != 0) ? lst_tail[h] : NIL_NODE;
      OP_CURR, OP_REMOVE: n = lst_cur[h];
      OP_NEXT: begin
        if (is_nd(lst_cur[h])) n = nd_fwd[lst_cur[h]];
        else n = (lst_len[h] != 0 && !lst_beyond[h]) ? lst_head[h] : NIL_NODE;
      end
      OP_PREV: begin
        if (is_nd(lst_cur[h])) n = nd_bwd[lst_cur[h]];
        else n = (lst_len[h] != 0 && lst_beyond[h]) ? lst_tail[h] : NIL_NODE;
      end
      default: n = NIL_NODE;
    endcase
    return !is_nd(n) || nd_written[n];
  endfunction

  function automatic logic [31:0] rand_item();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Directed: every operation, empty-list cases, cursor ends, bad opcode
  task automatic test_directed();
    send_op(OP_CREATE, 0, 0, 0);
    send_op(OP_COUNT, 0, 0, 0);
    send_op(OP_FIRST, 0, 0, 0);
    send_op(OP_NEXT, 0, 0, 0);
    send_op(OP_PREV, 0, 0, 0);
    send_op(OP_TRIM, 0, 0, 0);
    send_op(OP_CURR, 0, 0, 0);
    send_op(OP_INS_AFTER, 0, 0, 32'hFFFF_FFFF);
    send_op(OP_INS_BEFORE, 0, 0, 32'h0);
    send_op(OP_APPEND, 0, 0, 32'hA5A5_5A5A);
    send_op(OP_PREPEND, 0, 0, 32'h5A5A_A5A5);
    send_op(OP_LAST, 0, 0, 0);
    send_op(OP_NEXT, 0, 0, 0);
    send_op(OP_NEXT, 0, 0, 0);
    send_op(OP_PREV, 0, 0, 0);
    send_op(OP_REMOVE, 0, 0, 0);
    send_op(OP_CREATE, 0, 0, 0);
    send_op(OP_APPEND, 1, 0, 32'h1234_5678);
    send_op(OP_CONCAT, 0, 1, 0);
    send_op(OP_CONCAT, 0, 0, 0);
    send_op(4'd15, 0, 0, 0);
    send_op(OP_FREE, 0, 0, 0);
  endtask

  // Exhaust the handle pool, then the node pool, then release everything
  task automatic test_pool_exhaustion();
    for (int i = 0; i < LISTS + 1; i++) send_op(OP_CREATE, 0, 0, 0);
    for (int i = 0; i < NODES + 1; i++) send_op(OP_APPEND, 3, 0, $urandom());
    send_op(OP_INS_BEFORE, 3, 0, 0);
    send_op(OP_COUNT, 3, 0, 0);
    wait_drained();
    for (int i = 0; i < LISTS; i++) send_op(OP_FREE, i, 0, 0);
  endtask

  // Random traffic: mostly inserts and navigation on live lists
  task automatic test_random(input int count);
    in_t req;
    int w, h;
    for (int i = 0; i < count; i++) begin
      h = pick_handle();
      w = $urandom_range(0, 99);
      if (w < 6) req.operation = OP_CREATE;
      else if (w < 30) req.operation = 4'(OP_INS_AFTER + $urandom_range(0, 3));
      else if (w < 70) req.operation = 4'(OP_COUNT + $urandom_range(0, 5));
      else if (w < 84) req.operation = 4'(OP_REMOVE + $urandom_range(0, 1));
      else if (w < 91) req.operation = OP_CONCAT;
      else if (w < 96) req.operation = OP_FREE;
      else req.operation = 4'd15;
      req.list_id = h[3:0];
      req.second_list_id = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'(pick_handle());
      req.item_value = rand_item();
      if (!read_safe(req.operation, h)) req.operation = OP_COUNT;
      if (i == count / 2) wait_drained();
      send_request(req);
    end
  endtask

  initial begin
    reset_tables();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pool_exhaustion();
    test_random(1100);
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d results; every opcode plus invalid",
             sent, received);
    $display("Covered handle and node pool exhaustion, cursor ends, concat, free");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/plce_pkg.sv
hw/rtl/plce_ctrl.sv
hw/rtl/plce_dp.sv
hw/rtl/pooled_list_cursor_engine.sv
sim/tb.sv
